// ===== rtl/core/plist_pkg.sv =====
// Shared constants, codes and the result record of the positional list store.
// Used by plist_ctrl and positional_list_store_unit; depends on nothing.
package plist_pkg;

  // List size and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // Field widths of the request and result beats.
  localparam int MODE_W = 2;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  // Stream data widths, rounded up to whole bytes.
  localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int M_BITS_W  = VAL_W + LEN_W + 1;
  localparam int M_TDATA_W = ((M_BITS_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_BITS_W;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RETRIEVE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // One finished result, passed from the sequencer to the output register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
  } result_t;

endpackage

// ===== rtl/core/plist_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/plist_ctrl.sv =====
// Request sequencer of the positional list store: checks each request, shifts
// entries through the list RAM one per cycle and builds the result.
// Depends on plist_pkg and plist_ram.
module plist_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [plist_pkg::MODE_W-1:0]   in_mode,
  input  logic [plist_pkg::POS_W-1:0]    in_pos,
  input  logic [plist_pkg::VAL_W-1:0]    in_val,
  output logic                           res_valid,
  input  logic                           res_ready,
  output plist_pkg::result_t             res
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOVE  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_READ  = 6'b001000,
    S_FINAL = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t                         state;
  logic [plist_pkg::CNT_W-1:0]    count;
  logic [plist_pkg::MODE_W-1:0]   op;
  logic [plist_pkg::IDX_W-1:0]    rd_ptr;
  logic [plist_pkg::IDX_W-1:0]    stop;
  logic [plist_pkg::IDX_W-1:0]    slot;
  logic [plist_pkg::VAL_W-1:0]    val;
  logic                           pend;
  logic [plist_pkg::IDX_W-1:0]    pend_addr;
  plist_pkg::result_t             res_q;

  logic [plist_pkg::POS_W:0]      pos_x;
  logic [plist_pkg::POS_W:0]      cnt_x;
  logic                           pos_zero;
  logic                           ins_bad;
  logic                           at_bad;
  logic                           full;
  logic [plist_pkg::IDX_W-1:0]    p0;
  logic [plist_pkg::STAT_W-1:0]   chk_status;
  logic                           work;
  logic [plist_pkg::CNT_W-1:0]    count_fin;

  logic                           ram_we;
  logic [plist_pkg::IDX_W-1:0]    ram_waddr;
  logic [plist_pkg::VAL_W-1:0]    ram_wdata;
  logic                           ram_re;
  logic [plist_pkg::VAL_W-1:0]    ram_rdata;

  // List storage.
  plist_ram #(
    .WIDTH (plist_pkg::VAL_W),
    .DEPTH (plist_pkg::CAPACITY)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // Position checks on the incoming request against the current count.
  always_comb begin
    pos_x    = {1'b0, in_pos};
    cnt_x    = (plist_pkg::POS_W + 1)'(count);
    pos_zero = (in_pos == '0);
    ins_bad  = pos_zero || (pos_x > cnt_x + 1'b1);
    at_bad   = pos_zero || (pos_x > cnt_x);
    full     = (count == plist_pkg::CNT_W'(plist_pkg::CAPACITY));
    p0       = plist_pkg::IDX_W'(in_pos - 1'b1);
  end

  // Status of the request; only a clean insert, delete or retrieve needs the RAM.
  always_comb begin
    chk_status = plist_pkg::ST_OK;
    work       = 1'b0;
    unique case (in_mode)
      plist_pkg::MODE_INSERT: begin
        if (ins_bad) begin
          chk_status = plist_pkg::ST_RANGE;
        end else if (full) begin
          chk_status = plist_pkg::ST_FULL;
        end else begin
          work = 1'b1;
        end
      end
      plist_pkg::MODE_DELETE: begin
        if (count == '0) begin
          chk_status = plist_pkg::ST_EMPTY;
        end else if (at_bad) begin
          chk_status = plist_pkg::ST_RANGE;
        end else begin
          work = 1'b1;
        end
      end
      plist_pkg::MODE_RETRIEVE: begin
        if (at_bad) begin
          chk_status = plist_pkg::ST_RANGE;
        end else begin
          work = 1'b1;
        end
      end
      default: begin
        work = 1'b0;
      end
    endcase
  end

  // Count after the request completes.
  always_comb begin
    unique case (op)
      plist_pkg::MODE_INSERT: count_fin = count + 1'b1;
      plist_pkg::MODE_DELETE: count_fin = count - 1'b1;
      default:                count_fin = count;
    endcase
  end

  // RAM access: the read runs one entry ahead of the write-back of the shift.
  always_comb begin
    ram_re    = (state == S_MOVE) || (state == S_READ);
    ram_we    = ((state == S_MOVE) && pend) || (state == S_DRAIN) ||
                ((state == S_FINAL) && (op == plist_pkg::MODE_INSERT));
    ram_waddr = (state == S_FINAL) ? slot : pend_addr;
    ram_wdata = (state == S_FINAL) ? val : ram_rdata;
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res       = res_q;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (in_valid) begin
            if (!work) begin
              state <= S_RESP;
            end else if (in_mode == plist_pkg::MODE_INSERT) begin
              state <= (count > plist_pkg::CNT_W'(p0)) ? S_MOVE : S_FINAL;
            end else if (in_mode == plist_pkg::MODE_DELETE) begin
              state <= (plist_pkg::CNT_W'(p0) + 1'b1 < count) ? S_MOVE : S_FINAL;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_MOVE: begin
          pend <= 1'b1;
          if (rd_ptr == stop) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINAL;
        end
        S_READ: begin
          state <= S_FINAL;
        end
        S_FINAL: begin
          count <= count_fin;
          state <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload, shift pointers and the result record.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op   <= in_mode;
        slot <= p0;
        val  <= in_val;
        if (in_mode == plist_pkg::MODE_INSERT) begin
          rd_ptr <= plist_pkg::IDX_W'(count - 1'b1);
          stop   <= p0;
        end else if (in_mode == plist_pkg::MODE_DELETE) begin
          rd_ptr <= p0 + 1'b1;
          stop   <= plist_pkg::IDX_W'(count - 1'b1);
        end else begin
          rd_ptr <= p0;
          stop   <= p0;
        end
        res_q.status    <= chk_status;
        res_q.value_out <= '0;
        res_q.length    <= plist_pkg::LEN_W'(count);
        res_q.is_empty  <= (count == '0);
      end
      S_MOVE: begin
        pend_addr <= (op == plist_pkg::MODE_INSERT) ? rd_ptr + 1'b1 : rd_ptr - 1'b1;
        if (rd_ptr != stop) begin
          rd_ptr <= (op == plist_pkg::MODE_INSERT) ? rd_ptr - 1'b1 : rd_ptr + 1'b1;
        end
      end
      S_FINAL: begin
        res_q.status    <= plist_pkg::ST_OK;
        res_q.value_out <= (op == plist_pkg::MODE_RETRIEVE) ? ram_rdata : '0;
        res_q.length    <= plist_pkg::LEN_W'(count_fin);
        res_q.is_empty  <= (count_fin == '0);
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  // The count never passes the list size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= plist_pkg::CNT_W'(plist_pkg::CAPACITY))
    else $error("list count exceeds capacity");

  // The shift never reads the entry it is writing in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (ram_waddr == rd_ptr)))
    else $error("list RAM read and write hit the same entry");

  // The count only moves when a request completes.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_FINAL) |=> $stable(count))
    else $error("list count changed outside request completion");

  // The empty flag agrees with the reported length.
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.is_empty == (res.length == '0)))
    else $error("empty flag disagrees with length");

endmodule

// ===== rtl/core/positional_list_store_unit.sv =====
// Top level of the positional list store: stream ports, the request sequencer
// and the result output register. Depends on plist_pkg and plist_ctrl.
//
//  Channel   Dir  Fields (tdata / tuser)
//  s_axis    in   tdata: position, value_in, tuser: mode
//  m_axis    out  tdata: value_out, length, is_empty, tuser: status
//
// A request whose status is an error goes straight to the response; a retrieve
// first reads the list RAM. An insert or delete shifts its entries through the
// list RAM one entry per cycle, writes the last one back and then finishes; when
// no entry moves it goes straight to the final step.
// A new request is taken in the cycle after the previous result leaves the
// sequencer, even while that result still waits in the output register.
// Reset empties the list; entries are not cleared.
module positional_list_store_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] position, [39:8] value_in
  input  logic [plist_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] mode
  input  logic [plist_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] value_out, [36:32] length, [37] is_empty, [39:38] zero
  output logic [plist_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [plist_pkg::STAT_W-1:0]       m_axis_tuser
);

  logic                 res_valid;
  logic                 res_ready;
  plist_pkg::result_t   res;
  logic                 out_valid;
  plist_pkg::result_t   out_q;

  // Request sequencer with the list memory.
  plist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_pos    (s_axis_tdata[plist_pkg::POS_W-1:0]),
    .in_val    (s_axis_tdata[plist_pkg::POS_W +: plist_pkg::VAL_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads when empty or when its beat is taken.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // Result beat packing.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{plist_pkg::M_PAD_W{1'b0}}, out_q.is_empty, out_q.length,
                          out_q.value_out};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for positional_list_store_unit: drives list requests
// on the slave stream and checks every result beat against a behavioral list.
// Depends on plist_pkg and the RTL of positional_list_store_unit only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode code that the block treats as a no-op.
  localparam logic [plist_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  // Longest request: every entry moved, plus the response cycles.
  localparam int MAX_LATENCY   = plist_pkg::CAPACITY + 3;
  localparam int RANDOM_ITEMS  = 930;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 200;

  // Behavioral copy of the list and the queue of results still owed.
  class list_scoreboard;
    logic [plist_pkg::VAL_W-1:0] slots [plist_pkg::CAPACITY];
    int                          fill;
    plist_pkg::result_t          awaited [$];
    int                          errors;
    int                          checked;
    int                          reports;
    int                          mode_seen [4];
    int                          status_seen [4];

    // Applies one accepted request to the list and queues its result.
    function void apply_request(logic [plist_pkg::MODE_W-1:0] mode,
                                logic [plist_pkg::POS_W-1:0] pos,
                                logic [plist_pkg::VAL_W-1:0] val);
      plist_pkg::result_t res;
      int                 p;
      int                 i;
      p = pos;
      res = '0;
      res.status = plist_pkg::ST_OK;
      case (mode)
        plist_pkg::MODE_INSERT: begin
          if (p < 1 || p > fill + 1) begin
            res.status = plist_pkg::ST_RANGE;
          end else if (fill >= plist_pkg::CAPACITY) begin
            res.status = plist_pkg::ST_FULL;
          end else begin
            for (i = fill; i > p - 1; i--) slots[i] = slots[i-1];
            slots[p-1] = val;
            fill++;
          end
        end
        plist_pkg::MODE_DELETE: begin
          // An empty list is reported before the position is looked at.
          if (fill == 0) begin
            res.status = plist_pkg::ST_EMPTY;
          end else if (p < 1 || p > fill) begin
            res.status = plist_pkg::ST_RANGE;
          end else begin
            for (i = p - 1; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        plist_pkg::MODE_RETRIEVE: begin
          if (p < 1 || p > fill) begin
            res.status = plist_pkg::ST_RANGE;
          end else begin
            res.value_out = slots[p-1];
          end
        end
        default: begin
          // The spare mode leaves the list alone and reports success.
        end
      endcase
      res.length   = plist_pkg::LEN_W'(fill);
      res.is_empty = (fill == 0);
      mode_seen[mode]++;
      status_seen[res.status]++;
      awaited.push_back(res);
    endfunction

    function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (reports < 40) begin
        reports++;
        $display("%0t ns: %s differs, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    // Compares one result beat with the oldest outstanding result.
    function void check_response(plist_pkg::result_t got);
      plist_pkg::result_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing outstanding, actual status %0d",
                 $time, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.status != want.status) note_mismatch("status", want.status, got.status);
      if (got.value_out != want.value_out)
        note_mismatch("value_out", want.value_out, got.value_out);
      if (got.length != want.length) note_mismatch("length", want.length, got.length);
      if (got.is_empty != want.is_empty)
        note_mismatch("is_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [plist_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [plist_pkg::MODE_W-1:0]    s_axis_tuser = plist_pkg::MODE_INSERT;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [plist_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [plist_pkg::STAT_W-1:0]    m_axis_tuser;

  list_scoreboard     sb = new;
  plist_pkg::result_t observed;
  int                 sent;

  positional_list_store_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result monitor: every accepted beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      observed.status    = m_axis_tuser;
      observed.value_out = m_axis_tdata[plist_pkg::VAL_W-1:0];
      observed.length    = m_axis_tdata[plist_pkg::VAL_W +: plist_pkg::LEN_W];
      observed.is_empty  = m_axis_tdata[plist_pkg::VAL_W+plist_pkg::LEN_W];
      sb.check_response(observed);
    end
  end

  // Offers one request beat and returns at the edge that accepts it.
  task automatic offer(input logic [plist_pkg::MODE_W-1:0] mode,
                       input logic [plist_pkg::POS_W-1:0] pos,
                       input logic [plist_pkg::VAL_W-1:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {val, pos};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.apply_request(mode, pos, val);
    sent++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values lean on the signed extremes now and then.
  function automatic logic [plist_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Builds the next request from the current list length. Phase kind 0 mixes
  // the modes evenly, kind 1 leans toward inserts and kind 2 toward deletes.
  task automatic pick_request(input int kind, output logic [plist_pkg::MODE_W-1:0] mode,
                              output logic [plist_pkg::POS_W-1:0] pos,
                              output logic [plist_pkg::VAL_W-1:0] val);
    int r;
    int w;
    r = $urandom_range(0, 99);
    val = pick_value();
    if (r < 15) begin
      // Noise: any mode, any position.
      mode = plist_pkg::MODE_W'($urandom_range(0, 3));
      pos  = plist_pkg::POS_W'($urandom);
    end else if (r < 23) begin
      // Broken: position zero or one step past the legal end.
      mode = plist_pkg::MODE_W'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) pos = '0;
      else if (mode == plist_pkg::MODE_INSERT) pos = plist_pkg::POS_W'(sb.fill + 2);
      else pos = plist_pkg::POS_W'(sb.fill + 1);
    end else begin
      w = $urandom_range(0, 99);
      case (kind)
        1: begin
          if (w < 70) mode = plist_pkg::MODE_INSERT;
          else if (w < 82) mode = plist_pkg::MODE_DELETE;
          else mode = plist_pkg::MODE_RETRIEVE;
        end
        2: begin
          if (w < 70) mode = plist_pkg::MODE_DELETE;
          else if (w < 82) mode = plist_pkg::MODE_INSERT;
          else mode = plist_pkg::MODE_RETRIEVE;
        end
        default: begin
          if (w < 34) mode = plist_pkg::MODE_INSERT;
          else if (w < 67) mode = plist_pkg::MODE_DELETE;
          else mode = plist_pkg::MODE_RETRIEVE;
        end
      endcase
      if (mode == plist_pkg::MODE_INSERT)
        pos = plist_pkg::POS_W'($urandom_range(1, sb.fill + 1));
      else if (sb.fill > 0) pos = plist_pkg::POS_W'($urandom_range(1, sb.fill));
      else pos = plist_pkg::POS_W'($urandom_range(1, 4));
    end
  endtask

  // Result side: stretches of steady readiness, light and heavy stalling, and
  // one long hold-off that lets the block back up into its input.
  initial begin
    int seg_len;
    int style;
    int i;
    bit held;
    held = 1'b0;
    forever begin
      seg_len = $urandom_range(16, 120);
      style   = $urandom_range(0, 2);
      for (i = 0; i < seg_len; i++) begin
        if (!held && sb.checked >= HOLD_AFTER) begin
          held = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 99) < 80);
          default: begin
            if ($urandom_range(0, 99) < 5) begin
              m_axis_tready <= 1'b0;
              repeat ($urandom_range(8, 40)) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 1) == 1);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // Request side: reset, directed corner cases, then random phases.
  initial begin
    logic [plist_pkg::MODE_W-1:0] mode;
    logic [plist_pkg::POS_W-1:0]  pos;
    logic [plist_pkg::VAL_W-1:0]  val;
    int                           total;
    int                           kind;
    int                           span;
    int                           k;
    bit                           gappy;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty list: retrieve, delete with a legal and an illegal position.
    offer(plist_pkg::MODE_RETRIEVE, 8'd1, 32'h1234_5678);
    offer(plist_pkg::MODE_DELETE, 8'd1, '0);
    offer(plist_pkg::MODE_DELETE, 8'd0, '0);
    offer(MODE_SPARE, 8'd1, 32'hDEAD_BEEF);
    // Insert position checks, then build a short list at head, tail and middle.
    offer(plist_pkg::MODE_INSERT, 8'd0, 32'h1111_1111);
    offer(plist_pkg::MODE_INSERT, 8'd2, 32'h2222_2222);
    offer(plist_pkg::MODE_INSERT, 8'd1, 32'h7FFF_FFFF);
    offer(plist_pkg::MODE_INSERT, 8'd2, 32'h8000_0000);
    offer(plist_pkg::MODE_INSERT, 8'd1, 32'hFFFF_FFFF);
    offer(plist_pkg::MODE_INSERT, 8'd2, 32'h0000_0000);
    offer(plist_pkg::MODE_INSERT, 8'd255, 32'h5A5A_5A5A);
    // Read back every entry and probe past the end.
    for (k = 1; k <= 4; k++) offer(plist_pkg::MODE_RETRIEVE, plist_pkg::POS_W'(k), '0);
    offer(plist_pkg::MODE_RETRIEVE, 8'd5, '0);
    offer(plist_pkg::MODE_RETRIEVE, 8'd255, '0);
    offer(plist_pkg::MODE_RETRIEVE, 8'd0, '0);
    // Delete out of range, then from the middle, the tail and the head.
    offer(plist_pkg::MODE_DELETE, 8'd5, '0);
    offer(plist_pkg::MODE_DELETE, 8'd2, '0);
    offer(plist_pkg::MODE_DELETE, 8'd3, '0);
    offer(plist_pkg::MODE_DELETE, 8'd1, '0);
    offer(MODE_SPARE, 8'd255, 32'hA5A5_A5A5);

    // Random phases; fill-leaning phases reach a full list, drain-leaning
    // ones run it dry.
    total = sent + RANDOM_ITEMS;
    while (sent < total) begin
      kind  = $urandom_range(0, 2);
      span  = $urandom_range(30, 70);
      gappy = ($urandom_range(0, 3) != 0);
      for (k = 0; k < span && sent < total; k++) begin
        pick_request(kind, mode, pos, val);
        offer(mode, pos, val);
        if (gappy) pause(pick_gap());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray beat.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (MAX_LATENCY + 4) @(posedge clk);

    $display("Sent %0d requests: %0d insert, %0d delete, %0d retrieve, %0d spare mode.",
             sent, sb.mode_seen[plist_pkg::MODE_INSERT],
             sb.mode_seen[plist_pkg::MODE_DELETE],
             sb.mode_seen[plist_pkg::MODE_RETRIEVE], sb.mode_seen[MODE_SPARE]);
    $display("Results by status: %0d ok, %0d out of range, %0d empty, %0d full; %0d checked.",
             sb.status_seen[plist_pkg::ST_OK], sb.status_seen[plist_pkg::ST_RANGE],
             sb.status_seen[plist_pkg::ST_EMPTY], sb.status_seen[plist_pkg::ST_FULL],
             sb.checked);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Run did not finish in time, %0d results outstanding.", sb.awaited.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
